// ----- rtl/core/apfp_pkg.sv -----
// Package for the API frame ADC sample parser: frame byte codes, position
// constants and the sample range check. No dependencies.
package apfp_pkg;

    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 5;
    localparam int SLOT_N   = 3;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [POS_W-1:0]    pos_t;

    // header bytes
    localparam byte_t HDR_START  = 8'h7E;
    localparam byte_t HDR_LEN_HI = 8'h00;
    localparam byte_t HDR_LEN_LO = 8'h10;
    localparam byte_t HDR_KIND   = 8'h83;

    localparam sample_t SAMPLE_LIMIT = 16'd1023;

    // frame positions
    localparam pos_t POS_HUNT      = 5'd0;
    localparam pos_t POS_HDR_LEN_H = 5'd1;
    localparam pos_t POS_HDR_LEN_L = 5'd2;
    localparam pos_t POS_HDR_KIND  = 5'd3;
    localparam pos_t POS_ADDR_HI   = 5'd4;
    localparam pos_t POS_ADDR_LO   = 5'd5;
    localparam pos_t POS_SKIP_END  = 5'd10;
    localparam pos_t POS_SAMP_0_LO = 5'd12;
    localparam pos_t POS_LAST      = 5'd18;

    // sample is usable when strictly between 0 and the limit
    function automatic logic sample_ok(input sample_t s);
        return (s != '0) && (s < SAMPLE_LIMIT);
    endfunction

endpackage

// ----- rtl/core/api_frame_adc_sample_parser.sv -----
// The result is shown in the cycle after the last sample byte is accepted.
// Throughput: one rx byte per cycle unless stalled; a frame of 19 bytes yields at most one result.
// The only input stall: a result waits unread while the next byte may close a frame.
// Reset (rst_n low, async): hunting for header, no result pending, sender_address 0.
// Held samples and the output payload are not reset.
// Depends on apfp_pkg.
module api_frame_adc_sample_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  apfp_pkg::sample_t     cfg_data,
    // byte input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  apfp_pkg::byte_t       rx_byte,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output apfp_pkg::sample_t     sample0,
    output apfp_pkg::sample_t     sample1,
    output apfp_pkg::sample_t     sample2,
    output apfp_pkg::sample_t     sample3,
    output logic                  valid0,
    output logic                  valid1,
    output logic                  valid2,
    output logic                  valid3
);
    import apfp_pkg::*;

    // control state
    pos_t    pos_reg, pos_next;
    byte_t   hold_reg, hold_next;
    sample_t sender_reg;
    logic    out_valid_reg, out_valid_next;

    // payload storage, written before read within a frame
    sample_t held_samples [SLOT_N];
    sample_t sample_reg [4];
    logic    [3:0] flag_reg;

    logic    accept;
    logic    out_take;
    logic    emit;
    logic    store_sample;
    sample_t word;
    pos_t    slot_ofs;
    logic    [1:0] slot;

    // config is always taken; it must be written only while the parser is idle, which the block leaves unchecked
    assign cfg_ready = 1'b1;

    assign out_take = out_valid_reg & ~out_stall;
    // only a byte at the last position can produce a result, so stall
    // just that byte while an unread result sits in the output register
    assign in_stall = out_valid_reg & out_stall & (pos_reg == POS_LAST);
    assign accept   = in_valid & ~in_stall;

    assign word     = {hold_reg, rx_byte};
    assign slot_ofs = pos_reg - POS_SAMP_0_LO;
    assign slot     = slot_ofs[2:1];

    // per-byte frame walk
    always_comb
    begin
        pos_next     = pos_reg;
        hold_next    = hold_reg;
        emit         = 1'b0;
        store_sample = 1'b0;
        if (accept)
        begin
            if (pos_reg == POS_HUNT || pos_reg > POS_LAST)
            begin
                pos_next = (rx_byte == HDR_START) ? POS_HDR_LEN_H : POS_HUNT;
            end
            else if (pos_reg == POS_HDR_LEN_H)
            begin
                pos_next = (rx_byte == HDR_LEN_HI) ? POS_HDR_LEN_L : POS_HUNT;
            end
            else if (pos_reg == POS_HDR_LEN_L)
            begin
                pos_next = (rx_byte == HDR_LEN_LO) ? POS_HDR_KIND : POS_HUNT;
            end
            else if (pos_reg == POS_HDR_KIND)
            begin
                pos_next = (rx_byte == HDR_KIND) ? POS_ADDR_HI : POS_HUNT;
            end
            else if (pos_reg == POS_ADDR_HI)
            begin
                hold_next = rx_byte;
                pos_next  = POS_ADDR_LO;
            end
            else if (pos_reg == POS_ADDR_LO)
            begin
                pos_next = (word == sender_reg) ? pos_reg + 5'd1 : POS_HUNT;
            end
            else if (pos_reg <= POS_SKIP_END)
            begin
                pos_next = pos_reg + 5'd1;
            end
            else if (pos_reg[0])
            begin
                // odd positions carry a sample's high byte
                hold_next = rx_byte;
                pos_next  = pos_reg + 5'd1;
            end
            else if (pos_reg < POS_LAST)
            begin
                store_sample = 1'b1;
                pos_next     = pos_reg + 5'd1;
            end
            else
            begin
                emit     = 1'b1;
                pos_next = POS_HUNT;
            end
        end
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_take)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_HUNT;
            hold_reg      <= '0;
            sender_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                sender_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_sample)
            held_samples[slot] <= word;
    end

    // result register, range flags computed on the way in
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            sample_reg[0] <= held_samples[0];
            sample_reg[1] <= held_samples[1];
            sample_reg[2] <= held_samples[2];
            sample_reg[3] <= word;
            flag_reg      <= {sample_ok(word), sample_ok(held_samples[2]),
                              sample_ok(held_samples[1]), sample_ok(held_samples[0])};
        end
    end

    assign out_valid = out_valid_reg;
    assign sample0   = sample_reg[0];
    assign sample1   = sample_reg[1];
    assign sample2   = sample_reg[2];
    assign sample3   = sample_reg[3];
    assign valid0    = flag_reg[0];
    assign valid1    = flag_reg[1];
    assign valid2    = flag_reg[2];
    assign valid3    = flag_reg[3];

endmodule

// ----- rtl/core/apfp_checker.sv -----
// Port-level checks for api_frame_adc_sample_parser, bound into that module.
// Depends on apfp_pkg.
module apfp_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input apfp_pkg::sample_t     sample0,
    input apfp_pkg::sample_t     sample1,
    input apfp_pkg::sample_t     sample2,
    input apfp_pkg::sample_t     sample3,
    input logic                  valid0,
    input logic                  valid1,
    input logic                  valid2,
    input logic                  valid3
);
    import apfp_pkg::*;

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample0) && $stable(sample1)
            && $stable(sample2) && $stable(sample3))
        else $error("result changed while stalled");

    // flags agree with samples
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> valid0 == sample_ok(sample0) && valid1 == sample_ok(sample1)
            && valid2 == sample_ok(sample2) && valid3 == sample_ok(sample3))
        else $error("range flag mismatch");

    // a new result follows an accepted byte
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("result without request");

    // input stalls only behind a stalled result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without cause");

endmodule

bind api_frame_adc_sample_parser apfp_checker u_apfp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample0   (sample0),
    .sample1   (sample1),
    .sample2   (sample2),
    .sample3   (sample3),
    .valid0    (valid0),
    .valid1    (valid1),
    .valid2    (valid2),
    .valid3    (valid3)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for api_frame_adc_sample_parser: random byte streams of good,
// broken and foreign frames, with a built-in frame decoder that predicts each result.
// Depends on apfp_pkg and the parser RTL only.
module testbench;
    import apfp_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned LONG_HOLD     = 1200;   // receiver hold-off, in cycles
    localparam int unsigned DRAIN_LIMIT   = 4000;   // wait for results before giving up
    localparam int unsigned SETTLE_CYCLES = 4;      // result shows the cycle after last byte
    localparam int unsigned MAX_REPORTS   = 10;

    typedef sample_t [3:0] quad_t;

    // one result as the block shows it
    typedef struct packed {
        quad_t      smp;
        logic [3:0] ok;
    } adc_set_t;

    // one byte request with the idle cycles the sender spends before offering it
    typedef struct packed {
        logic [4:0] gap;
        byte_t      data;
    } rx_request_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    sample_t cfg_data = '0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    byte_t   rx_byte = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    sample_t sample0, sample1, sample2, sample3;
    logic    valid0, valid1, valid2, valid3;

    api_frame_adc_sample_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample0   (sample0),
        .sample1   (sample1),
        .sample2   (sample2),
        .sample3   (sample3),
        .valid0    (valid0),
        .valid1    (valid1),
        .valid2    (valid2),
        .valid3    (valid3)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame decoder: mirrors the parser's view of the byte stream.
    // ------------------------------------------------------------------
    pos_t        frame_pos = POS_HUNT;
    byte_t       high_byte = '0;
    sample_t     held_slot [3];
    sample_t     sender_addr = '0;      // register as last written
    adc_set_t    frames_expected [$];   // decoded frames not yet seen at the output
    int unsigned fault_count = 0;

    function automatic logic in_range(input sample_t s);
        return (s != '0) && (s < SAMPLE_LIMIT);
    endfunction

    function automatic void decode_byte(input byte_t b);
        sample_t  word;
        adc_set_t frame;
        word = {high_byte, b};
        if (frame_pos == POS_HUNT || frame_pos > POS_LAST)
            frame_pos = (b == HDR_START) ? POS_HDR_LEN_H : POS_HUNT;
        else if (frame_pos == POS_HDR_LEN_H)
            frame_pos = (b == HDR_LEN_HI) ? POS_HDR_LEN_L : POS_HUNT;
        else if (frame_pos == POS_HDR_LEN_L)
            frame_pos = (b == HDR_LEN_LO) ? POS_HDR_KIND : POS_HUNT;
        else if (frame_pos == POS_HDR_KIND)
            // a wrong byte is swallowed, never rechecked as a start byte
            frame_pos = (b == HDR_KIND) ? POS_ADDR_HI : POS_HUNT;
        else if (frame_pos == POS_ADDR_HI)
        begin
            high_byte = b;
            frame_pos = POS_ADDR_LO;
        end
        else if (frame_pos == POS_ADDR_LO)
            frame_pos = (word == sender_addr) ? pos_t'(POS_ADDR_LO + 1) : POS_HUNT;
        else if (frame_pos <= POS_SKIP_END)
            frame_pos = pos_t'(frame_pos + 1);
        else if (frame_pos[0])
        begin
            // odd positions carry the high byte of a sample
            high_byte = b;
            frame_pos = pos_t'(frame_pos + 1);
        end
        else if (frame_pos < POS_LAST)
        begin
            held_slot[(frame_pos - POS_SAMP_0_LO) >> 1] = word;
            frame_pos = pos_t'(frame_pos + 1);
        end
        else
        begin
            frame.smp = {word, held_slot[2], held_slot[1], held_slot[0]};
            for (int i = 0; i < 4; i++)
                frame.ok[i] = in_range(frame.smp[i]);
            frames_expected.push_back(frame);
            frame_pos = POS_HUNT;
        end
    endfunction

    function automatic void log_fault(input string msg);
        if (fault_count < MAX_REPORTS)
            $display("[%0t] FAULT: %s", $realtime, msg);
        fault_count++;
    endfunction

    // ------------------------------------------------------------------
    // Byte sender. Requests come from byte_queue; each one waits its own
    // gap before being offered, and stays put until the block takes it.
    // ------------------------------------------------------------------
    rx_request_t byte_queue [$];
    logic        rx_taken = 1'b0;
    byte_t       taken_byte;
    int unsigned gap_left = 0;
    logic        gap_armed = 1'b0;

    always @(posedge clk)
    begin
        rx_taken   = rst_n && in_valid && !in_stall;
        taken_byte = rx_byte;
    end

    always @(negedge clk)
    begin
        logic  nxt_valid;
        byte_t nxt_byte;
        nxt_valid = in_valid;
        nxt_byte  = rx_byte;
        if (rx_taken)
        begin
            decode_byte(taken_byte);
            nxt_valid = 1'b0;
        end
        if (rst_n && !nxt_valid && byte_queue.size() != 0)
        begin
            if (!gap_armed)
            begin
                gap_left  = byte_queue[0].gap;
                gap_armed = 1'b1;
            end
            if (gap_left == 0)
            begin
                nxt_valid = 1'b1;
                nxt_byte  = byte_queue[0].data;
                void'(byte_queue.pop_front());
                gap_armed = 1'b0;
            end
            else
                gap_left--;
        end
        in_valid <= nxt_valid;
        rx_byte  <= nxt_byte;
    end

    // ------------------------------------------------------------------
    // Result side: monitor checks at the rising edge, receiver decides
    // stall at the falling edge.
    // ------------------------------------------------------------------
    logic        result_taken = 1'b0;
    logic        hold_req = 1'b0;     // toggled by the sequencer to ask for a long hold
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;
    int unsigned wait_left = 0;
    logic        recv_idle = 1'b1;

    always @(posedge clk)
    begin
        adc_set_t got;
        adc_set_t want;
        result_taken = rst_n && out_valid && !out_stall;
        if (result_taken)
        begin
            got.smp = {sample3, sample2, sample1, sample0};
            got.ok  = {valid3, valid2, valid1, valid0};
            if (frames_expected.size() == 0)
                log_fault($sformatf("result with no frame pending: %h %h %h %h",
                                    sample0, sample1, sample2, sample3));
            else
            begin
                want = frames_expected.pop_front();
                for (int i = 0; i < 4; i++)
                begin
                    if (got.smp[i] !== want.smp[i])
                        log_fault($sformatf("sample%0d expected %h got %h",
                                            i, want.smp[i], got.smp[i]));
                    if (got.ok[i] !== want.ok[i])
                        log_fault($sformatf("valid%0d expected %b got %b",
                                            i, want.ok[i], got.ok[i]));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (result_taken)
        begin
            // switch between stalling and free-running stretches now and then
            if ($urandom_range(0, 5) == 0)
                recv_idle = !recv_idle;
            wait_left = recv_idle ? $urandom_range(0, 19) : 0;
        end
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (out_valid && wait_left != 0)
        begin
            wait_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // run-away guard
    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    logic        sender_idle = 1'b1;
    int unsigned bytes_pushed = 0;

    function automatic byte_t header_at(input int j);
        case (j)
            0:       return HDR_START;
            1:       return HDR_LEN_HI;
            2:       return HDR_LEN_LO;
            default: return HDR_KIND;
        endcase
    endfunction

    function automatic void push_byte(input byte_t b);
        rx_request_t req;
        req.data = b;
        req.gap  = sender_idle ? 5'($urandom_range(0, 19)) : 5'd0;
        byte_queue.push_back(req);
        bytes_pushed++;
    endfunction

    // noise leans on the start byte so that false starts are common
    function automatic byte_t noise_byte();
        return ($urandom_range(0, 5) == 0) ? HDR_START : byte_t'($urandom_range(0, 255));
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd1022;
            3:       return 16'd1023;
            4:       return 16'hFFFF;
            5:       return sample_t'($urandom_range(1, 1022));
            6:       return sample_t'($urandom_range(0, 2047));
            default: return sample_t'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic quad_t quad(input sample_t s0, s1, s2, s3);
        return {s3, s2, s1, s0};
    endfunction

    function automatic quad_t random_quad();
        return quad(pick_sample(), pick_sample(), pick_sample(), pick_sample());
    endfunction

    function automatic void push_frame(input sample_t addr, input quad_t smp,
                                       input int unsigned trail);
        for (int j = 0; j < 4; j++)
            push_byte(header_at(j));
        push_byte(addr[15:8]);
        push_byte(addr[7:0]);
        repeat (5) push_byte(byte_t'($urandom_range(0, 255)));
        for (int i = 0; i < 4; i++)
        begin
            push_byte(smp[i][15:8]);
            push_byte(smp[i][7:0]);
        end
        repeat (trail) push_byte(noise_byte());
    endfunction

    // header correct up to byte k, then a wrong byte, then some noise
    function automatic void push_broken(input int k);
        byte_t bad;
        for (int j = 0; j < k; j++)
            push_byte(header_at(j));
        do
            bad = byte_t'($urandom_range(0, 255));
        while (bad == header_at(k));
        push_byte(bad);
        repeat ($urandom_range(0, 4)) push_byte(noise_byte());
    endfunction

    task automatic run_random(input int unsigned nbytes);
        int unsigned stop_at;
        int unsigned kind;
        stop_at = bytes_pushed + nbytes;
        while (bytes_pushed < stop_at)
        begin
            if ($urandom_range(0, 7) == 0)
                sender_idle = !sender_idle;
            kind = $urandom_range(0, 19);
            if (kind < 13)
                push_frame(sender_addr, random_quad(), $urandom_range(0, 3));
            else if (kind < 16)
                push_broken($urandom_range(0, 3));
            else if (kind < 18)
                // one address bit off
                push_frame(sender_addr ^ (16'h1 << $urandom_range(0, 15)), random_quad(),
                           $urandom_range(0, 2));
            else
                repeat ($urandom_range(1, 6)) push_byte(noise_byte());
        end
    endtask

    // sender empty, every decoded frame seen (or given up on), then a quiet settle wait
    task automatic drain();
        int unsigned waited;
        do
            @(posedge clk);
        while (byte_queue.size() != 0 || in_valid);
        waited = 0;
        while (frames_expected.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        while (frames_expected.size() != 0)
        begin
            void'(frames_expected.pop_front());
            log_fault("decoded frame never showed at the output");
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sender_addr(input sample_t value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sender_addr = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: register still at its reset value of zero
        push_frame(16'h0000, quad(16'd0, 16'd1, 16'd1022, 16'd1023), 0);
        push_frame(16'h0000, quad(16'hFFFF, 16'h03FF, 16'h0400, 16'h03FE), 2);
        // header pattern inside the samples must not resync
        push_frame(16'h0000, quad(16'h7E00, 16'h1083, 16'h7E7E, 16'h0001), 0);
        // doubled start byte: the second one breaks the header and is dropped
        push_byte(HDR_START);
        push_frame(16'h0000, quad(16'd5, 16'd6, 16'd7, 16'd8), 0);
        for (int k = 0; k < 4; k++)
            push_broken(k);
        // foreign sender, lowest and highest address bit
        push_frame(16'h0001, random_quad(), 0);
        push_frame(16'h8000, random_quad(), 1);
        push_frame(16'h0000, random_quad(), 1);
        drain();

        write_sender_addr(16'hFFFF);
        run_random(330);
        drain();

        write_sender_addr(sample_t'($urandom_range(1, 65534)));
        sender_idle = 1'b0;
        run_random(330);
        // long receiver hold while bytes keep coming, so the input backs up
        hold_req = !hold_req;
        drain();

        write_sender_addr(16'h0000);
        run_random(330);
        drain();

        write_sender_addr(sample_t'($urandom_range(0, 65535)));
        run_random(330);
        drain();

        if (fault_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/apfp_pkg.sv
rtl/core/api_frame_adc_sample_parser.sv
rtl/core/apfp_checker.sv
bench/testbench.sv
